[sv/fixed_partition_fit_allocator_defines.svh]
// Assertion helpers used by the allocator top module.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fpfa_pkg.sv]
package fpfa_pkg;

   localparam int NUM_PARTS_DEF = 16;
   localparam int SIZE_BITS_DEF = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_LAST,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;   // latch the accepted item, restart the scan
      logic scan;      // issue one table read
      logic load_wr;   // write the loaded entry
      logic commit;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic req_alloc; // item on the input port is an allocate
      logic scan_last; // last table slot is being read
      logic out_busy;  // output register holds an item that is not taken
   } sts_type;

endpackage

[sv/fixed_partition_fit_allocator.sv]
// Fixed partition allocator: a table of NUM_PARTS partitions (size, start, free mark).
// Request channel (req_*): operation selects load or allocate. A load writes the slot
// given by req_entry_index and marks it free; an allocate asks for req_request_size
// under req_policy (first, best or worst fit, lowest index on a tie).
// Result channel (rsp_*): exactly one item per request item. A granted allocate
// returns the start and slot index; a load or a miss returns all zero.
// A load writes its table entry, then commits its result. An allocate scans all
// slots first: the scan reads one table entry per cycle from the partition RAM
// port and compares it with the best candidate so far; then it commits its result.
// One item is worked on at a time; req_stall is high from acceptance until the result
// enters the output register, so a new item is not taken before the last one's result
// is committed, and a stall on the result side can delay that.
// The output register lets the next item be accepted while a result waits; if the
// receiver still stalls when the following result is ready, the block holds it.
// Reset clears every free mark, so no partition can be allocated until loaded, and
// drops any result not yet taken. req_stall is high during reset.
module fixed_partition_fit_allocator import fpfa_pkg::*; #(
   parameter int NUM_PARTS = NUM_PARTS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_entry_size,
   input  logic [15:0] req_entry_start,
   input  logic [15:0] req_request_size,
   input  logic [1:0]  req_policy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [15:0] rsp_grant_start,
   output logic [3:0]  rsp_grant_index
);

`include "fixed_partition_fit_allocator_defines.svh"

   cmd_type cmd;
   sts_type sts;

   fpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fpfa_datapath #(
      .NUM_PARTS (NUM_PARTS),
      .SIZE_BITS (SIZE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_entry_size   (req_entry_size),
      .req_entry_start  (req_entry_start),
      .req_request_size (req_request_size),
      .req_policy       (req_policy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_grant_start  (rsp_grant_start),
      .rsp_grant_index  (rsp_grant_index)
   );

   `FPFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted item did not make the block busy")
   `FPFA_ASSERT_SAME(a_nogrant_zero, clock, reset, rsp_valid && !rsp_granted, rsp_grant_start == 16'd0 && rsp_grant_index == 4'd0, "result without grant carries nonzero fields")
   `FPFA_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid, "committed result not presented")
   `FPFA_ASSERT_SAME(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.capture, cmd.scan, cmd.load_wr, cmd.commit}), "controller issued overlapping commands")

endmodule

[sv/fpfa_ram.sv]
module fpfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/fpfa_datapath.sv]
module fpfa_datapath import fpfa_pkg::*; #(
   parameter int NUM_PARTS = NUM_PARTS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        req_operation,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_entry_size,
   input  logic [15:0] req_entry_start,
   input  logic [15:0] req_request_size,
   input  logic [1:0]  req_policy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [15:0] rsp_grant_start,
   output logic [3:0]  rsp_grant_index
);

   localparam int SizeW = (SIZE_BITS < 16) ? SIZE_BITS : 16;
   localparam int IdxW  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
   localparam int RamW  = SizeW + 16;

   // latched item
   logic              op_ff;
   logic [3:0]        idx_ff;
   logic [SizeW-1:0]  esz_ff;
   logic [15:0]       est_ff;
   logic [SizeW-1:0]  want_ff;
   logic [1:0]        pol_ff;

   // scan control
   logic [IdxW-1:0]   cnt_ff, cnt_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IdxW-1:0]   chk_idx_ff, chk_idx_in;

   // best candidate so far
   logic              pick_vld_ff, pick_vld_in;
   logic [IdxW-1:0]   pick_idx_ff, pick_idx_in;
   logic [SizeW-1:0]  pick_size_ff, pick_size_in;
   logic [15:0]       pick_start_ff, pick_start_in;

   logic [NUM_PARTS-1:0] free_ff, free_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_granted_ff, rsp_granted_in;
   logic [15:0]       rsp_start_ff, rsp_start_in;
   logic [3:0]        rsp_index_ff, rsp_index_in;

   logic              in_range;
   logic [IdxW-1:0]   ld_addr;
   logic              ram_wr_en;
   logic [RamW-1:0]   rd_data;
   logic [SizeW-1:0]  rd_size;
   logic [15:0]       rd_start;
   logic              fits;
   logic              take;
   logic              grant;

   assign in_range  = 32'(idx_ff) < NUM_PARTS;
   assign ld_addr   = IdxW'(idx_ff);
   assign ram_wr_en = cmd.load_wr && in_range;
   assign rd_size   = rd_data[RamW-1:16];
   assign rd_start  = rd_data[15:0];

   fpfa_ram #(
      .WIDTH (RamW),
      .DEPTH (NUM_PARTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ld_addr),
      .wr_data ({esz_ff, est_ff}),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign fits = chk_vld_ff && free_ff[chk_idx_ff] && (rd_size >= want_ff);

   always_comb begin
      case (pol_ff)
         POL_FIRST: take = fits && !pick_vld_ff;
         POL_BEST:  take = fits && (!pick_vld_ff || rd_size < pick_size_ff);
         POL_WORST: take = fits && (!pick_vld_ff || rd_size > pick_size_ff);
         default:   take = 1'b0;
      endcase
   end

   assign grant = (op_ff == OP_ALLOC) && pick_vld_ff;

   always_comb begin
      cnt_in        = cnt_ff;
      chk_vld_in    = cmd.scan;
      chk_idx_in    = cnt_ff;
      pick_vld_in   = pick_vld_ff;
      pick_idx_in   = pick_idx_ff;
      pick_size_in  = pick_size_ff;
      pick_start_in = pick_start_ff;
      if (cmd.capture) begin
         cnt_in      = '0;
         pick_vld_in = 1'b0;
      end else begin
         if (cmd.scan) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (take) begin
            pick_vld_in   = 1'b1;
            pick_idx_in   = chk_idx_ff;
            pick_size_in  = rd_size;
            pick_start_in = rd_start;
         end
      end
   end

   always_comb begin
      free_in = free_ff;
      if (ram_wr_en) begin
         free_in[ld_addr] = 1'b1;
      end
      if (cmd.commit && grant) begin
         free_in[pick_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_index_in   = rsp_index_ff;
      if (cmd.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = grant;
         rsp_start_in   = grant ? pick_start_ff : 16'd0;
         rsp_index_in   = grant ? 4'(pick_idx_ff) : 4'd0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         pick_vld_ff  <= 1'b0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         pick_vld_ff  <= pick_vld_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         idx_ff  <= req_entry_index;
         esz_ff  <= SizeW'(req_entry_size);
         est_ff  <= req_entry_start;
         want_ff <= SizeW'(req_request_size);
         pol_ff  <= req_policy;
      end
      chk_idx_ff     <= chk_idx_in;
      pick_idx_ff    <= pick_idx_in;
      pick_size_ff   <= pick_size_in;
      pick_start_ff  <= pick_start_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign sts.req_alloc = (req_operation == OP_ALLOC);
   assign sts.scan_last = (cnt_ff == IdxW'(NUM_PARTS - 1));
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_grant_start = rsp_start_ff;
   assign rsp_grant_index = rsp_index_ff;

endmodule

[sv/fpfa_ctrl.sv]
module fpfa_ctrl import fpfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = sts.req_alloc ? S_SCAN : S_LOAD;
            end
         end
         S_LOAD: state_in = S_DONE;
         S_SCAN: begin
            if (sts.scan_last) begin
               state_in = S_LAST;
            end
         end
         // last read data is compared here
         S_LAST: state_in = S_DONE;
         S_DONE: begin
            if (!sts.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.capture = req_valid;
         S_LOAD: cmd.load_wr = 1'b1;
         S_SCAN: cmd.scan    = 1'b1;
         S_LAST: cmd         = '0;
         S_DONE: cmd.commit  = !sts.out_busy;
         default: cmd        = '0;
      endcase
   end

   assign req_stall = reset || (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top import fpfa_pkg::*; ();

   localparam int NUM_PARTS = NUM_PARTS_DEF;
   localparam logic [1:0] POL_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1900;
   localparam int DIR_ROWS = 24;
   // drain allowance after the last result; both sides insert random idle gaps
   localparam int DRAIN_CYCLES = 2 * (NUM_PARTS + 3);
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic        op;
      logic [3:0]  idx;
      logic [15:0] esz;
      logic [15:0] est;
      logic [15:0] rsz;
      logic [1:0]  pol;
   } fit_req_type;

   typedef struct packed {
      logic        granted;
      logic [15:0] start;
      logic [3:0]  index;
   } fit_rsp_type;

   typedef struct packed {
      fit_req_type req;
      logic        known;   // expected result typed in below
      fit_rsp_type rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_LOAD;
   logic [3:0]  req_entry_index = '0;
   logic [15:0] req_entry_size = '0;
   logic [15:0] req_entry_start = '0;
   logic [15:0] req_request_size = '0;
   logic [1:0]  req_policy = POL_FIRST;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_granted;
   logic [15:0] rsp_grant_start;
   logic [3:0]  rsp_grant_index;

   // shadow partition table
   logic [15:0] tbl_size [NUM_PARTS];
   logic [15:0] tbl_start [NUM_PARTS];
   logic        tbl_free [NUM_PARTS];

   fit_rsp_type grant_q[$];
   dir_row_type dir_tbl [DIR_ROWS];
   int          err_cnt = 0;
   int          idle_cycles = 0;
   int          rsp_hold = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;

   fixed_partition_fit_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_entry_size   (req_entry_size),
      .req_entry_start  (req_entry_start),
      .req_request_size (req_request_size),
      .req_policy       (req_policy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_grant_start  (rsp_grant_start),
      .rsp_grant_index  (rsp_grant_index)
   );

   always #1 clock = ~clock;

   // Applies one item to the shadow table and returns the grant it causes.
   function automatic fit_rsp_type fit_apply(input fit_req_type it);
      fit_rsp_type res;
      int          pick;
      res = '0;
      pick = -1;
      if (it.op == OP_LOAD) begin
         tbl_size[it.idx] = it.esz;
         tbl_start[it.idx] = it.est;
         tbl_free[it.idx] = 1'b1;
      end else if (it.pol != POL_UNUSED) begin
         for (int i = 0; i < NUM_PARTS; i++) begin
            if (tbl_free[i] && tbl_size[i] >= it.rsz) begin
               // first fit keeps the lowest index; strict compares keep ties low
               if (pick < 0)
                  pick = i;
               else if (it.pol == POL_BEST && tbl_size[i] < tbl_size[pick])
                  pick = i;
               else if (it.pol == POL_WORST && tbl_size[i] > tbl_size[pick])
                  pick = i;
            end
         end
         if (pick >= 0) begin
            tbl_free[pick] = 1'b0;
            res.granted = 1'b1;
            res.start = tbl_start[pick];
            res.index = 4'(pick);
         end
      end
      return res;
   endfunction

   function automatic fit_req_type gen_item();
      fit_req_type it;
      int          r;
      int          v;
      it.op = ($urandom_range(0, 9) < 4) ? OP_LOAD : OP_ALLOC;
      it.idx = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      // a few repeated sizes give best/worst fit ties
      if (r < 4)
         it.esz = 16'h0040 << (3 * $urandom_range(0, 3));
      else if (r < 8)
         it.esz = 16'($urandom);
      else if (r == 8)
         it.esz = '0;
      else
         it.esz = '1;
      it.est = 16'($urandom);
      r = $urandom_range(0, 9);
      if (r < 6) begin
         // land just around a size in the table: exact hits and near misses
         v = int'(tbl_size[$urandom_range(0, NUM_PARTS - 1)]) + int'($urandom_range(0, 2)) - 1;
         if (v < 0)
            v = 0;
         if (v > 65535)
            v = 65535;
         it.rsz = 16'(v);
      end else if (r < 8)
         it.rsz = 16'($urandom);
      else if (r == 8)
         it.rsz = '0;
      else
         it.rsz = '1;
      r = $urandom_range(0, 9);
      if (r < 3)
         it.pol = POL_FIRST;
      else if (r < 6)
         it.pol = POL_BEST;
      else if (r < 9)
         it.pol = POL_WORST;
      else
         it.pol = POL_UNUSED;
      return it;
   endfunction

   task automatic send_item(input fit_req_type it, input logic known,
                            input fit_rsp_type typed);
      fit_rsp_type pred;
      int          gap;
      gap = req_quiet ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= it.op;
      req_entry_index <= it.idx;
      req_entry_size <= it.esz;
      req_entry_start <= it.est;
      req_request_size <= it.rsz;
      req_policy <= it.pol;
      do @(posedge clock); while (req_stall);
      pred = fit_apply(it);
      grant_q.push_back(known ? typed : pred);
      if ($urandom_range(0, 60) == 0)
         req_quiet = !req_quiet;
   endtask

   initial begin
      dir_tbl = '{
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_UNUSED}, 1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd0,  16'hFFFF, 16'hFFFF, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd15, 16'h0000, 16'h0000, 16'hFFFF, POL_WORST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd5,  16'h0100, 16'h1234, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd9,  16'h0100, 16'hABCD, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd3,  16'h0800, 16'h4000, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_UNUSED}, 1'b1, '{1'b0, 16'h0000, 4'd0}},
         // tie between slots 5 and 9 goes to the lower one
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0100, POL_BEST},   1'b1, '{1'b1, 16'h1234, 4'd5}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_WORST},  1'b1, '{1'b1, 16'hFFFF, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_FIRST},  1'b1, '{1'b1, 16'h4000, 4'd3}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'hFFFF, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_BEST},   1'b1, '{1'b1, 16'h0000, 4'd15}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_WORST},  1'b1, '{1'b1, 16'hABCD, 4'd9}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd7,  16'h8000, 16'h5555, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd8,  16'h7FFF, 16'hAAAA, 16'h0000, POL_FIRST},  1'b1, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h8000, POL_BEST},   1'b1, '{1'b1, 16'h5555, 4'd7}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h7FFF, POL_FIRST},  1'b1, '{1'b1, 16'hAAAA, 4'd8}},
         // reload of a used slot frees it again
         '{'{OP_LOAD,  4'd15, 16'hFFFF, 16'h0F0F, 16'h0000, POL_FIRST},  1'b0, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_LOAD,  4'd2,  16'hFFFF, 16'hF0F0, 16'h0000, POL_FIRST},  1'b0, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'hFFFF, POL_WORST},  1'b0, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'h0000, POL_BEST},   1'b0, '{1'b0, 16'h0000, 4'd0}},
         '{'{OP_ALLOC, 4'd0,  16'h0000, 16'h0000, 16'hFFFF, POL_UNUSED}, 1'b0, '{1'b0, 16'h0000, 4'd0}}
      };
      for (int i = 0; i < NUM_PARTS; i++) begin
         tbl_size[i] = '0;
         tbl_start[i] = '0;
         tbl_free[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int r = 0; r < DIR_ROWS; r++)
         send_item(dir_tbl[r].req, dir_tbl[r].known, dir_tbl[r].rsp);
      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_item(gen_item(), 1'b0, '0);
      @(negedge clock);
      req_valid <= 1'b0;
      while (grant_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("** fixed_partition_fit_allocator: PASSED **");
      else
         $display("** fixed_partition_fit_allocator: FAILED **");
      $finish;
   end

   // result side back-pressure, drawn per item
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : result_check
      fit_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grant_q.size() == 0) begin
            $display("%0t: unexpected item: granted %0d start %h index %0d", $time,
                     rsp_granted, rsp_grant_start, rsp_grant_index);
            err_cnt++;
         end else begin
            want = grant_q.pop_front();
            if (rsp_granted !== want.granted) begin
               $display("%0t: granted exp %0d got %0d", $time, want.granted, rsp_granted);
               err_cnt++;
            end
            if (rsp_grant_start !== want.start) begin
               $display("%0t: grant_start exp %h got %h", $time, want.start, rsp_grant_start);
               err_cnt++;
            end
            if (rsp_grant_index !== want.index) begin
               $display("%0t: grant_index exp %0d got %0d", $time, want.index, rsp_grant_index);
               err_cnt++;
            end
         end
         if ($urandom_range(0, 50) == 0)
            rsp_quiet = !rsp_quiet;
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** fixed_partition_fit_allocator: FAILED **");
            $finish;
         end
      end
   end

endmodule

[fixed_partition_fit_allocator.f]
+incdir+sv
sv/fpfa_pkg.sv
sv/fpfa_ram.sv
sv/fpfa_datapath.sv
sv/fpfa_ctrl.sv
sv/fixed_partition_fit_allocator.sv
dv/tb_top.sv
